// ===== rtl/scaler_rate_and_wrap_tracker_core_macros.svh =====
// Assertion macros for the counter wrap and rate tracker.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef SCALER_RATE_AND_WRAP_TRACKER_CORE_MACROS_SVH
`define SCALER_RATE_AND_WRAP_TRACKER_CORE_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define SRWT_ASSERT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("srwt: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRWT_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("srwt: next-cycle check failed");

`else

`define SRWT_ASSERT(lbl, pre, post)
`define SRWT_ASSERT_NXT(lbl, pre, post)

`endif

`endif

// ===== rtl/srwt_pkg.sv =====
package srwt_pkg;

  localparam int CountW   = 32;
  localparam int ChanW    = 5;
  localparam int ClkHzW   = 20;
  localparam int RateW    = 48;
  localparam int ExtW     = 64;
  localparam int FracW    = 4;

  // Dividend is diff * clock_hz scaled by the four fraction bits.
  localparam int ProdW    = CountW + ClkHzW;
  localparam int NumW     = ProdW + FracW;
  localparam int DivSteps = NumW;
  localparam int StepW    = $clog2(DivSteps);

  localparam int CfgIdxW  = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REF_CHANNEL = 1'b0,
    CFG_CLOCK_HZ    = 1'b1
  } cfg_idx_e;

  localparam logic [ChanW-1:0]  RefChanReset = 5'd31;
  localparam logic [ClkHzW-1:0] ClkHzReset   = 20'd1000;

  typedef struct packed {
    logic [ChanW-1:0] chan;
    logic [ExtW-1:0]  ext;
    logic [RateW-1:0] rate;
    logic             rate_valid;
    logic             wrapped;
  } result_t;

endpackage

// ===== rtl/scaler_rate_and_wrap_tracker_core.sv =====
// Channel   | Dir | Handshake                 | Payload
// ----------+-----+---------------------------+--------------------------------------
// s_*       | in  | s_tvalid_i / s_tready_o   | tdata: count; tuser: channel
// m_*       | out | m_tvalid_o / m_tready_i   | tdata: extended_count, rate_q4;
//           |     |                           | tuser: out_channel, rate_valid, wrapped
// cfg_*     | in  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A dividing sample passes through the table read, one multiply, 56 restoring divide
// steps and a hand-off to the output register; other samples skip the multiply and divide.
// The next sample is accepted only once the hand-off has returned the block to idle.
// Reset clears the per-channel valid flags at once, so no clearing pass is needed.
// The input is held off while a sample is in work, and a finished result waits in
// its own stage, stalling the block, while the output register is still occupied.
`include "scaler_rate_and_wrap_tracker_core_macros.svh"

module scaler_rate_and_wrap_tracker_core #(
  parameter int CHANNELS = 32
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,

  input  logic                                       s_tvalid_i,
  output logic                                       s_tready_o,
  // [31:0] count
  input  logic [srwt_pkg::CountW-1:0]                s_tdata_i,
  // [4:0] channel
  input  logic [srwt_pkg::ChanW-1:0]                 s_tuser_i,

  output logic                                       m_tvalid_o,
  input  logic                                       m_tready_i,
  // [63:0] extended_count, [111:64] rate_q4
  output logic [srwt_pkg::ExtW+srwt_pkg::RateW-1:0]  m_tdata_o,
  // [4:0] out_channel, [5] rate_valid, [6] wrapped
  output logic [srwt_pkg::ChanW+1:0]                 m_tuser_o,

  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [srwt_pkg::CfgIdxW-1:0]               cfg_index_i,
  input  logic [srwt_pkg::ClkHzW-1:0]                cfg_data_i
);

  import srwt_pkg::*;

  localparam int ChIdxW = $clog2(CHANNELS);
  localparam int EntryW = 2 * CountW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e                state_q;
  logic                  m_tvalid_q;
  logic [ChanW-1:0]      ref_chan_q;
  logic [ClkHzW-1:0]     clk_hz_q;
  logic [CountW-1:0]     interval_q;
  logic [CHANNELS-1:0]   valid_q;

  logic [ChanW-1:0]      chan_q;
  logic [CountW-1:0]     cnt_q;
  logic                  in_range_q;
  logic                  ent_valid_q;
  logic [NumW-1:0]       num_q;
  logic [CountW-1:0]     rem_q;
  logic [RateW-1:0]      quot_q;
  logic                  over_q;
  logic [StepW-1:0]      step_q;
  result_t               res_q;
  result_t               out_q;

  logic                  accept;
  logic                  in_range_in;
  logic                  out_free;
  logic [ChIdxW-1:0]     rd_addr;
  logic [ChIdxW-1:0]     wr_addr;
  logic                  ram_we;
  logic [EntryW-1:0]     ram_wdata;
  logic [EntryW-1:0]     ram_rdata;
  logic [CountW-1:0]     prev;
  logic [CountW-1:0]     wrap_old;
  logic [CountW-1:0]     wrap_new;
  logic [CountW:0]       sub_a;
  logic [CountW:0]       sub_b;
  logic [CountW+1:0]     sub_res;
  logic                  borrow;
  logic [CountW-1:0]     diff;
  logic                  is_ref;
  logic                  last_step;
  logic [RateW-1:0]      quot_nx;
  logic                  over_nx;
  logic [ProdW-1:0]      prod;

  assign accept      = s_tvalid_i && s_tready_o;
  assign s_tready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !m_tvalid_q || m_tready_i;
  assign in_range_in = int'(s_tuser_i) < CHANNELS;

  assign rd_addr = ChIdxW'(s_tuser_i);
  assign wr_addr = ChIdxW'(chan_q);

  // Each table entry holds the wrap count above the previous sample. An entry that
  // was never written since reset reads as zero through its valid flag.
  assign prev     = ent_valid_q ? ram_rdata[CountW-1:0]      : '0;
  assign wrap_old = ent_valid_q ? ram_rdata[EntryW-1:CountW] : '0;

  // One subtractor serves both the sample difference and every divide step. Its
  // borrow is the wrap flag in the first use and the inverted quotient bit in the second.
  always_comb begin
    if (state_q == ST_DIV) begin
      sub_a = {rem_q, num_q[NumW-1]};
      sub_b = {1'b0, interval_q};
    end else begin
      sub_a = {1'b0, cnt_q};
      sub_b = {1'b0, prev};
    end
  end

  assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow  = sub_res[CountW+1];
  assign diff    = sub_res[CountW-1:0];

  assign wrap_new  = wrap_old + CountW'(borrow);
  assign is_ref    = in_range_q && (chan_q == ref_chan_q);
  assign last_step = (step_q == StepW'(DivSteps - 1));

  // Quotient bits above the 48-bit rate leave through the top of the quotient
  // register and mark the result for saturation.
  assign quot_nx = {quot_q[RateW-2:0], !borrow};
  assign over_nx = over_q || quot_q[RateW-1];

  // The difference waits in the low bits of the dividend register for the multiply.
  assign prod = ProdW'(num_q[CountW-1:0]) * ProdW'(clk_hz_q);

  assign ram_we    = (state_q == ST_READ) && in_range_q;
  assign ram_wdata = {wrap_new, cnt_q};

  srwt_ram #(
    .WIDTH (EntryW),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Sequencer, configuration registers, tick interval, channel valid flags and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
      ref_chan_q <= RefChanReset;
      clk_hz_q   <= ClkHzReset;
      interval_q <= '0;
      valid_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_REF_CHANNEL: ref_chan_q <= cfg_data_i[ChanW-1:0];
          CFG_CLOCK_HZ:    clk_hz_q   <= cfg_data_i;
          default:         ;
        endcase
      end

      // In the hand-off state the output valid is set below instead.
      if (m_tvalid_q && m_tready_i && (state_q != ST_DONE)) begin
        m_tvalid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          if (in_range_q) begin
            valid_q[wr_addr] <= 1'b1;
          end
          if (is_ref) begin
            interval_q <= diff;
          end
          if (in_range_q && !is_ref && (interval_q != '0)) begin
            state_q <= ST_MUL;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_MUL: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (last_step) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid_q <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          chan_q      <= s_tuser_i;
          cnt_q       <= s_tdata_i;
          in_range_q  <= in_range_in;
          ent_valid_q <= valid_q[rd_addr];
        end
      end
      ST_READ: begin
        res_q.chan    <= chan_q;
        res_q.wrapped <= in_range_q && borrow;
        res_q.ext     <= in_range_q ? {wrap_new, cnt_q} : ExtW'(cnt_q);
        num_q         <= NumW'(diff);
        if (is_ref) begin
          res_q.rate       <= RateW'({clk_hz_q, {FracW{1'b0}}});
          res_q.rate_valid <= 1'b1;
        end else begin
          res_q.rate       <= '0;
          res_q.rate_valid <= 1'b0;
        end
      end
      ST_MUL: begin
        num_q  <= {prod, {FracW{1'b0}}};
        rem_q  <= '0;
        quot_q <= '0;
        over_q <= 1'b0;
        step_q <= '0;
      end
      ST_DIV: begin
        num_q  <= {num_q[NumW-2:0], 1'b0};
        rem_q  <= borrow ? sub_a[CountW-1:0] : sub_res[CountW-1:0];
        quot_q <= quot_nx;
        over_q <= over_nx;
        step_q <= step_q + StepW'(1);
        if (last_step) begin
          res_q.rate       <= over_nx ? '1 : quot_nx;
          res_q.rate_valid <= 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_q <= res_q;
        end
      end
      default: ;
    endcase
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = {out_q.rate, out_q.ext};
  assign m_tuser_o  = {out_q.wrapped, out_q.rate_valid, out_q.chan};

  // Only one sample is in work at a time.
  `SRWT_ASSERT_NXT(a_single_item, accept, !s_tready_o)
  // The divide step counter never runs past the dividend width.
  `SRWT_ASSERT(a_step_bound, state_q == ST_DIV, int'(step_q) < DivSteps)
  // A new result appears only from the hand-off state.
  `SRWT_ASSERT(a_result_source, $rose(m_tvalid_q), $past(state_q == ST_DONE))
  // A channel outside the table never reports a rate.
  `SRWT_ASSERT(a_out_of_range, m_tvalid_o && (int'(m_tuser_o[ChanW-1:0]) >= CHANNELS),
               !m_tuser_o[ChanW])

endmodule

// ===== rtl/srwt_ram.sv =====
module srwt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
